### design/dstq_pkg.sv
// Package for the deadline-sorted task queue.
// Holds sizes, operation and status codes, and the item and slot types.
// Used by every module in the design folder.
package dstq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] deadline;
		logic [15:0] task_id;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] assigned_id;
		logic [4:0]  occupancy;
		logic        head_valid;
		logic [15:0] head_id;
		logic [15:0] head_deadline;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] deadline;
		logic [15:0] id;
	} slot_t;

	// Finished step handed from the sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic [1:0]       status;
		logic [15:0]      assigned_id;
		logic [CNT_W-1:0] count;
		slot_t            head;
	} fin_t;

endpackage

### design/deadline_sorted_task_queue.sv
// Top level of the deadline-sorted task queue: handshakes and result register.
// Depends on dstq_pkg and dstq_ctrl.
//
// Request channel (req_valid, req_ready, req): operation 0 inserts a task
// with the given deadline, operation 1 removes the task carrying task_id.
// Response channel (rsp_valid, rsp_ready, rsp): one item per request with
// status, the id given to an inserted task, occupancy and the head task.
// Tasks are held in deadline order, equal deadlines in arrival order.
// Each request walks the stored tasks once through one compare unit,
// one slot memory read port and one write port. A rejected insert into
// a full queue skips the walk. req_ready is high only while no request
// is being worked on, so the next request is accepted at the earliest in
// the cycle after the response loads. Reset empties the queue and
// restarts the id counter at zero; no clearing pass is needed. A
// response waiting for rsp_ready does not stop the next request from
// being accepted and worked on; that request's response is held until
// the output register is free.
module deadline_sorted_task_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dstq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dstq_pkg::rsp_item_t rsp
);
	import dstq_pkg::*;

	logic      idle;
	logic      fin_free;
	fin_t      fin;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	assign req_ready = idle;
	assign fin_free  = !rsp_valid_q || rsp_ready;

	dstq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && req_ready),
		.item     (req),
		.fin_free (fin_free),
		.idle     (idle),
		.fin      (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin.valid && fin_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Empty queue reports a zero head
	always_ff @(posedge clk) begin
		if (fin.valid && fin_free) begin
			rsp_q.status        <= fin.status;
			rsp_q.assigned_id   <= fin.assigned_id;
			rsp_q.occupancy     <= 5'(fin.count);
			rsp_q.head_valid    <= (fin.count != '0);
			rsp_q.head_id       <= (fin.count != '0) ? fin.head.id : 16'd0;
			rsp_q.head_deadline <= (fin.count != '0) ? fin.head.deadline : 16'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/dstq_cmp.sv
// Shared compare unit of the task queue.
// Insert: later-deadline test; remove: id match. Depends on dstq_pkg.
module dstq_cmp (
	input  logic          mode,
	input  logic [15:0]   key,
	input  dstq_pkg::slot_t slot,
	output logic          hit
);
	import dstq_pkg::*;

	always_comb begin
		case (mode)
			OP_INSERT: hit = (slot.deadline > key);
			OP_REMOVE: hit = (slot.id == key);
			default:   hit = 1'b0;
		endcase
	end

endmodule

### design/dstq_ctrl.sv
// Sequencer and slot memory of the task queue.
// Walks the stored slots at most once per item through the shared compare unit.
// Depends on dstq_pkg and dstq_cmp.
module dstq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dstq_pkg::req_item_t item,
	input  logic                fin_free,
	output logic                idle,
	output dstq_pkg::fin_t      fin
);
	import dstq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic             op_q;
	logic [15:0]      key_q;
	slot_t            carry_q;
	logic             moved_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      idc_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	slot_t            rdata_s1;
	slot_t            head_q;
	logic [1:0]       status_q;
	logic [15:0]      assigned_q;

	slot_t            mem_q [CAPACITY];

	logic             hit;
	logic             issue;
	logic             finish;
	logic             we;
	logic [IDX_W-1:0] waddr;
	slot_t            wdata;

	dstq_cmp u_cmp (
		.mode (op_q),
		.key  (key_q),
		.slot (rdata_s1),
		.hit  (hit)
	);

	assign issue  = (state_q == S_RUN) && (addr_q != count_q);
	assign finish = (state_q == S_RUN) && (addr_q == count_q) && !rd_valid_s1;

	// Insert: from the first later deadline on, push each slot one place down.
	// Remove: after the match, pull each slot one place up.
	always_comb begin
		we    = 1'b0;
		waddr = rd_idx_s1;
		wdata = carry_q;
		if (rd_valid_s1) begin
			if (op_q == OP_INSERT) begin
				we = moved_q || hit;
			end else begin
				we    = moved_q;
				waddr = rd_idx_s1 - 1'b1;
				wdata = rdata_s1;
			end
		end else if (finish && op_q == OP_INSERT) begin
			we    = 1'b1;
			waddr = count_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (issue) begin
			rdata_s1 <= mem_q[addr_q[IDX_W-1:0]];
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INSERT;
			key_q       <= '0;
			carry_q     <= '0;
			count_q     <= '0;
			idc_q       <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			moved_q     <= 1'b0;
			status_q    <= STATUS_DONE;
			assigned_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= item.operation;
						key_q   <= (item.operation == OP_INSERT) ? item.deadline : item.task_id;
						carry_q <= '{deadline: item.deadline, id: idc_q};
						moved_q <= 1'b0;
						addr_q  <= '0;
						if (item.operation == OP_INSERT && count_q == CNT_W'(CAPACITY)) begin
							status_q   <= STATUS_FULL;
							assigned_q <= '0;
							state_q    <= S_FIN;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (rd_valid_s1) begin
						if (op_q == OP_INSERT) begin
							if (moved_q || hit) begin
								carry_q <= rdata_s1;
								moved_q <= 1'b1;
							end
						end else if (hit) begin
							moved_q <= 1'b1;
						end
					end
					if (finish) begin
						state_q <= S_FIN;
						if (op_q == OP_INSERT) begin
							count_q    <= count_q + 1'b1;
							idc_q      <= idc_q + 16'd1;
							status_q   <= STATUS_DONE;
							assigned_q <= idc_q;
						end else begin
							assigned_q <= '0;
							if (moved_q) begin
								count_q  <= count_q - 1'b1;
								status_q <= STATUS_DONE;
							end else begin
								status_q <= STATUS_NOT_FOUND;
							end
						end
					end
				end
				S_FIN: begin
					if (fin_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Mirror slot 0 so the head needs no extra read
	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			head_q <= wdata;
		end
	end

	assign idle            = (state_q == S_IDLE);
	assign fin.valid       = (state_q == S_FIN);
	assign fin.status      = status_q;
	assign fin.assigned_id = assigned_q;
	assign fin.count       = count_q;
	assign fin.head        = head_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_read_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == S_RUN)
		else $error("slot read outside a pass");

	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		finish && op_q == OP_INSERT |=> idc_q == 16'($past(idc_q) + 16'd1))
		else $error("id counter did not advance on insert");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && status_q == STATUS_FULL |-> count_q == CNT_W'(CAPACITY))
		else $error("full status with free slots");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_RUN |-> !we)
		else $error("slot write outside a pass");

endmodule
